FILE: rtl/abcrv_pkg.sv
// ----------------------------------------------------------------------------
// abcrv_pkg: shared types and constants of the A/B config record validator
// Transaction structs, record layout lookup, check limits and result codes.
// ----------------------------------------------------------------------------
package abcrv_pkg;

  // Record layout and check limits
  localparam logic [5:0]  RecBytes   = 6'd46;
  localparam logic [5:0]  IdxMax     = 6'd63;
  localparam logic [31:0] RecMagic   = 32'h4E43_4647;
  localparam logic [15:0] RecSchema  = 16'd1;
  localparam logic [15:0] RecLength  = 16'd46;
  localparam logic [31:0] HashBasis  = 32'd2166136261;
  localparam logic [31:0] HashPrime  = 32'd16777619;
  localparam logic [31:0] TimeLow    = 32'd1704067200;
  localparam logic [31:0] TimeHigh   = 32'd2145916800;
  localparam logic [15:0] SyncMax    = 16'(24 * 60);
  localparam logic [7:0]  StateMax   = 8'd2;
  localparam logic [5:0]  SumFirst   = 6'd12;
  localparam logic [5:0]  SumLast    = 6'd15;

  // Failure reasons
  localparam logic [3:0] FailNone     = 4'd0;
  localparam logic [3:0] FailSize     = 4'd1;
  localparam logic [3:0] FailMagic    = 4'd2;
  localparam logic [3:0] FailSchema   = 4'd3;
  localparam logic [3:0] FailLength   = 4'd4;
  localparam logic [3:0] FailState    = 4'd5;
  localparam logic [3:0] FailWake     = 4'd6;
  localparam logic [3:0] FailSync     = 4'd7;
  localparam logic [3:0] FailPhase    = 4'd8;
  localparam logic [3:0] FailLastSync = 4'd9;
  localparam logic [3:0] FailChecksum = 4'd10;

  // Load status codes
  localparam logic [1:0] LoadPrimary   = 2'd0;
  localparam logic [1:0] LoadSecondary = 2'd1;
  localparam logic [1:0] LoadNone      = 2'd2;
  localparam logic [1:0] LoadNotFinal  = 2'd3;

  typedef enum logic [3:0] {
    FLD_NONE,
    FLD_MAGIC,
    FLD_SCHEMA,
    FLD_LENGTH,
    FLD_GEN,
    FLD_SUM,
    FLD_STATE,
    FLD_WAKE,
    FLD_SYNC,
    FLD_PHASE,
    FLD_LAST
  } fld_kind_e;

  typedef struct packed {
    fld_kind_e  kind;
    logic [1:0] k;     // byte position inside the field
    logic       tail;  // final byte of the field
  } fld_info_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       slot_is_b;
    logic       last_byte;
    logic       slot_absent;
  } in_item_t;

  typedef struct packed {
    logic        out_slot_is_b;
    logic        record_valid;
    logic [3:0]  fail_reason;
    logic [31:0] record_generation;
    logic        choose_b;
    logic [1:0]  load_status;
  } out_item_t;

  // Map a byte index onto the checked field that contains it
  function automatic fld_info_t field_lookup(logic [5:0] idx);
    fld_info_t  info;
    logic [5:0] start;
    logic [2:0] len;
    info.kind = FLD_NONE;
    start     = '0;
    len       = 3'd1;
    priority if (idx < 6'd4) begin
      info.kind = FLD_MAGIC;  start = 6'd0;  len = 3'd4;
    end else if (idx < 6'd6) begin
      info.kind = FLD_SCHEMA; start = 6'd4;  len = 3'd2;
    end else if (idx < 6'd8) begin
      info.kind = FLD_LENGTH; start = 6'd6;  len = 3'd2;
    end else if (idx < 6'd12) begin
      info.kind = FLD_GEN;    start = 6'd8;  len = 3'd4;
    end else if (idx < 6'd16) begin
      info.kind = FLD_SUM;    start = 6'd12; len = 3'd4;
    end else if (idx == 6'd22) begin
      info.kind = FLD_STATE;  start = 6'd22; len = 3'd1;
    end else if (idx == 6'd27) begin
      info.kind = FLD_WAKE;   start = 6'd27; len = 3'd1;
    end else if (idx >= 6'd28 && idx < 6'd30) begin
      info.kind = FLD_SYNC;   start = 6'd28; len = 3'd2;
    end else if (idx >= 6'd30 && idx < 6'd34) begin
      info.kind = FLD_PHASE;  start = 6'd30; len = 3'd4;
    end else if (idx >= 6'd34 && idx < 6'd38) begin
      info.kind = FLD_LAST;   start = 6'd34; len = 3'd4;
    end
    info.k    = 2'(idx - start);
    info.tail = (idx == 6'(start + 6'(len) - 6'd1));
    return info;
  endfunction

  function automatic logic time_ok(logic [31:0] v);
    return (v == '0) || (v >= TimeLow && v <= TimeHigh);
  endfunction

  function automatic logic wake_ok(logic [7:0] v);
    return (v == 8'd0) || (v == 8'd1) || (v == 8'd5) || (v == 8'd10) ||
           (v == 8'd20) || (v == 8'd30) || (v == 8'd60);
  endfunction

endpackage

FILE: rtl/ab_config_record_validator.sv
// ----------------------------------------------------------------------------
// ab_config_record_validator: A/B configuration record validator
// Streams slot A then slot B record bytes, hashes and checks each record,
// reports a verdict per slot and the A/B selection after slot B.
// ----------------------------------------------------------------------------
// Path: the transaction that ends a slot is taken into the input register;
//   its verdict is then registered in the result register for the output.
// Throughput: one byte per cycle unless the output stalls a verdict; the hash
//   constant-prime multiply and checks fit between input and result registers.
// Reset: clears the record counter, hash (to the FNV basis), captures and
//   the slot A verdict; both channels come up empty.
module ab_config_record_validator (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  abcrv_pkg::in_item_t  in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output abcrv_pkg::out_item_t out_data_o
);
  import abcrv_pkg::*;

  // Input register
  logic      in_valid_q, in_valid_d;
  in_item_t  in_item_q;

  // Record state
  logic [5:0]  idx_q, idx_d;
  logic [31:0] hash_q, hash_d;
  logic [31:0] shift_q, shift_d;
  logic [3:0]  fail_q, fail_d;
  logic [31:0] gen_q, gen_d;
  logic [31:0] sum_q, sum_d;
  logic        a_valid_q, a_valid_d;
  logic [31:0] a_gen_q, a_gen_d;

  // Result register
  logic      out_valid_q, out_valid_d;
  out_item_t out_item_q, out_item_d;

  // Datapath
  logic        produces, out_free, advance, load_in;
  fld_info_t   fld;
  logic [7:0]  hb;
  logic [31:0] hash_x, hash_mul, acc;
  logic [5:0]  idx_n;
  logic [31:0] hash_n, shift_n, gen_n, sum_n;
  logic [3:0]  fail_n, reason;
  logic        valid, choose, newer;
  logic [31:0] gen_out, gen_diff;
  logic [1:0]  status;

  // Handshake
  assign produces   = in_item_q.slot_absent | in_item_q.last_byte;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign advance    = in_valid_q && (!produces || out_free);
  assign load_in    = !in_valid_q || advance;
  assign in_stall_o = !load_in;
  assign in_valid_d = load_in ? in_valid_i : in_valid_q;

  // Hash step, checksum bytes taken as zero
  assign fld      = field_lookup(idx_q);
  assign hb       = (idx_q >= SumFirst && idx_q <= SumLast) ? 8'd0 : in_item_q.data_byte;
  assign hash_x   = hash_q ^ {24'd0, hb};
  assign hash_mul = hash_x * HashPrime;
  assign acc      = ((fld.k == 2'd0) ? 32'd0 : shift_q) |
                    ({24'd0, in_item_q.data_byte} << {fld.k, 3'b000});

  // Byte intake: capture fields and record the first failing check
  always_comb begin
    idx_n   = idx_q;
    hash_n  = hash_q;
    shift_n = shift_q;
    fail_n  = fail_q;
    gen_n   = gen_q;
    sum_n   = sum_q;
    if (!in_item_q.slot_absent) begin
      idx_n = (idx_q < IdxMax) ? idx_q + 6'd1 : IdxMax;
      if (idx_q < RecBytes) begin
        hash_n = hash_mul;
        if (fld.kind != FLD_NONE) begin
          shift_n = acc;
        end
        if (fld.tail) begin
          unique case (fld.kind)
            FLD_MAGIC:  if (acc != RecMagic && fail_q == FailNone) fail_n = FailMagic;
            FLD_SCHEMA: if (acc[15:0] != RecSchema && fail_q == FailNone) fail_n = FailSchema;
            FLD_LENGTH: if (acc[15:0] != RecLength && fail_q == FailNone) fail_n = FailLength;
            FLD_GEN:    gen_n = acc;
            FLD_SUM:    sum_n = acc;
            FLD_STATE:  if (acc[7:0] > StateMax && fail_q == FailNone) fail_n = FailState;
            FLD_WAKE:   if (!wake_ok(acc[7:0]) && fail_q == FailNone) fail_n = FailWake;
            FLD_SYNC:   if (acc[15:0] > SyncMax && fail_q == FailNone) fail_n = FailSync;
            FLD_PHASE:  if (!time_ok(acc) && fail_q == FailNone) fail_n = FailPhase;
            FLD_LAST:   if (!time_ok(acc) && fail_q == FailNone) fail_n = FailLastSync;
            default:    ;
          endcase
        end
      end
    end
  end

  // Verdict and A/B choice
  assign gen_diff = gen_out - a_gen_q;
  assign newer    = (gen_diff != 32'd0) && !gen_diff[31];

  always_comb begin
    priority if (in_item_q.slot_absent || idx_n != RecBytes) begin
      reason = FailSize;
    end else if (fail_n != FailNone) begin
      reason = fail_n;
    end else if (hash_n != sum_n) begin
      reason = FailChecksum;
    end else begin
      reason = FailNone;
    end
    valid   = (reason == FailNone);
    gen_out = in_item_q.slot_absent ? 32'd0 : gen_n;
    choose  = 1'b0;
    status  = LoadNotFinal;
    if (in_item_q.slot_is_b) begin
      if (!valid && !a_valid_q) begin
        status = LoadNone;
      end else begin
        choose = valid && (!a_valid_q || newer);
        status = choose ? LoadSecondary : LoadPrimary;
      end
    end
  end

  // Next state: per-record state returns to reset after each verdict
  always_comb begin
    idx_d       = idx_q;
    hash_d      = hash_q;
    shift_d     = shift_q;
    fail_d      = fail_q;
    gen_d       = gen_q;
    sum_d       = sum_q;
    a_valid_d   = a_valid_q;
    a_gen_d     = a_gen_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_item_d  = out_item_q;
    if (advance) begin
      if (produces) begin
        idx_d   = '0;
        hash_d  = HashBasis;
        shift_d = '0;
        fail_d  = FailNone;
        gen_d   = '0;
        sum_d   = '0;
        if (in_item_q.slot_is_b) begin
          a_valid_d = 1'b0;
          a_gen_d   = '0;
        end else begin
          a_valid_d = valid;
          a_gen_d   = gen_out;
        end
        out_valid_d                  = 1'b1;
        out_item_d.out_slot_is_b     = in_item_q.slot_is_b;
        out_item_d.record_valid      = valid;
        out_item_d.fail_reason       = reason;
        out_item_d.record_generation = gen_out;
        out_item_d.choose_b          = choose;
        out_item_d.load_status       = status;
      end else begin
        idx_d   = idx_n;
        hash_d  = hash_n;
        shift_d = shift_n;
        fail_d  = fail_n;
        gen_d   = gen_n;
        sum_d   = sum_n;
      end
    end
  end

  // Control and record state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      idx_q       <= '0;
      hash_q      <= HashBasis;
      shift_q     <= '0;
      fail_q      <= FailNone;
      gen_q       <= '0;
      sum_q       <= '0;
      a_valid_q   <= 1'b0;
      a_gen_q     <= '0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      idx_q       <= idx_d;
      hash_q      <= hash_d;
      shift_q     <= shift_d;
      fail_q      <= fail_d;
      gen_q       <= gen_d;
      sum_q       <= sum_d;
      a_valid_q   <= a_valid_d;
      a_gen_q     <= a_gen_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (load_in) begin
      in_item_q <= in_data_i;
    end
    out_item_q <= out_item_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_item_q;

endmodule
